// File: sv/indexed_list_engine_top_macros.svh
// Assertion macros for the indexed list engine.
// Both expect i_clk and i_rst_n in scope.
`ifndef INDEXED_LIST_ENGINE_TOP_MACROS_SVH
`define INDEXED_LIST_ENGINE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ILE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`define ILE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define ILE_ASSERT_IMP(label, ante, cons, msg)

`define ILE_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// File: sv/ile_pkg.sv
`timescale 1ns / 1ps

package ile_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [2:0] CMD_GET    = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_SET    = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_TRUNC  = 3'd4;
    localparam logic [2:0] CMD_INDEX  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [8:0]         position;
        logic signed [31:0] element_value;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [7:0]         found_index;
        logic [8:0]         list_length;
    } t_rsp_item;

endpackage

// File: sv/indexed_list_engine_top.sv
`timescale 1ns / 1ps
// Channel   Ports                        Direction  Handshake
// command   start, busy, i_cmd_item      in         taken when start && !busy
// result    o_done, o_rsp                out        one-cycle strobe, no stall
//
// Get and set read the store once; truncate and rejected items finish when
// taken; remove and insert move the entries from position to the end one at a
// time; index-of scans up from entry 0 until a match or the end. The walk
// through the store (one read port and one write port) paces these. The result
// shows on the cycle after the item finishes, with busy already low.
// Reset clears state, length and done; the store keeps whatever it holds.

`include "indexed_list_engine_top_macros.svh"

module indexed_list_engine_top
    import ile_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_cmd_item i_cmd_item,
    output logic      busy,
    output logic      o_done,
    output t_rsp_item o_rsp
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_SHIFT = 5'b00100,
        S_SCAN  = 5'b01000,
        S_PUT   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [2:0]         r_cmd, n_cmd;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [31:0]        r_val, n_val;
    logic [31:0]        r_rd, n_rd;
    logic               r_done, n_done;
    t_rsp_item          r_rsp, n_rsp;

    logic               fin;
    logic [1:0]         f_status;
    logic [31:0]        f_rd;
    logic [7:0]         f_fidx;

    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [31:0]        wdata, rdata;
    logic               acc;

    assign acc = start && (r_state == S_IDLE);

    ile_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_cmd    = r_cmd;
        n_pos    = r_pos;
        n_val    = r_val;
        n_rd     = r_rd;
        n_done   = 1'b0;
        n_rsp    = r_rsp;
        fin      = 1'b0;
        f_status = ST_OK;
        f_rd     = '0;
        f_fidx   = '0;
        we       = 1'b0;
        waddr    = r_pos[ADDR_W-1:0];
        wdata    = r_val;
        raddr    = r_pos[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                // prefetch the first entry each command will need
                case (i_cmd_item.cmd)
                    CMD_INSERT: raddr = ADDR_W'(r_cnt - CNT_W'(1));
                    CMD_INDEX:  raddr = '0;
                    default:    raddr = i_cmd_item.position[ADDR_W-1:0];
                endcase
                if (acc) begin
                    n_cmd = i_cmd_item.cmd;
                    n_pos = i_cmd_item.position;
                    n_val = i_cmd_item.element_value;
                    case (i_cmd_item.cmd)
                        CMD_GET, CMD_SET, CMD_REMOVE: begin
                            if (i_cmd_item.position < r_cnt) begin
                                n_state = S_FETCH;
                            end else begin
                                fin      = 1'b1;
                                f_status = ST_RANGE;
                            end
                        end
                        CMD_INSERT: begin
                            if (i_cmd_item.position > r_cnt) begin
                                fin      = 1'b1;
                                f_status = ST_RANGE;
                            end else if (r_cnt >= CAP_CNT) begin
                                fin      = 1'b1;
                                f_status = ST_FULL;
                            end else if (i_cmd_item.position == r_cnt) begin
                                n_state = S_PUT;
                            end else begin
                                n_idx   = r_cnt[ADDR_W-1:0];
                                n_state = S_SHIFT;
                            end
                        end
                        CMD_TRUNC: begin
                            fin = 1'b1;
                            if (i_cmd_item.position < r_cnt) begin
                                n_cnt = i_cmd_item.position;
                            end else begin
                                f_status = ST_RANGE;
                            end
                        end
                        CMD_INDEX: begin
                            if (r_cnt == '0) begin
                                fin      = 1'b1;
                                f_status = ST_NOTFOUND;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                case (r_cmd)
                    CMD_SET: begin
                        we   = 1'b1;
                        fin  = 1'b1;
                        f_rd = rdata;
                    end
                    CMD_REMOVE: begin
                        n_rd  = rdata;
                        raddr = ADDR_W'(r_pos + CNT_W'(1));
                        if ((r_pos + CNT_W'(1)) < r_cnt) begin
                            n_idx   = r_pos[ADDR_W-1:0];
                            n_state = S_SHIFT;
                        end else begin
                            n_cnt = r_cnt - CNT_W'(1);
                            fin   = 1'b1;
                            f_rd  = rdata;
                        end
                    end
                    default: begin
                        fin  = 1'b1;
                        f_rd = rdata;
                    end
                endcase
            end
            S_SHIFT: begin
                // rdata holds the neighbor of r_idx read last cycle
                we    = 1'b1;
                waddr = r_idx;
                wdata = rdata;
                if (r_cmd == CMD_REMOVE) begin
                    raddr = r_idx + ADDR_W'(2);
                    if ((CNT_W'(r_idx) + CNT_W'(2)) < r_cnt) begin
                        n_idx = r_idx + ADDR_W'(1);
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                        fin   = 1'b1;
                        f_rd  = r_rd;
                    end
                end else begin
                    raddr = r_idx - ADDR_W'(2);
                    if (CNT_W'(r_idx) > (r_pos + CNT_W'(1))) begin
                        n_idx = r_idx - ADDR_W'(1);
                    end else begin
                        n_state = S_PUT;
                    end
                end
            end
            S_PUT: begin
                we    = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                fin   = 1'b1;
            end
            S_SCAN: begin
                raddr = r_idx + ADDR_W'(1);
                if (rdata == r_val) begin
                    fin    = 1'b1;
                    f_fidx = 8'(r_idx);
                end else if ((CNT_W'(r_idx) + CNT_W'(1)) < r_cnt) begin
                    n_idx = r_idx + ADDR_W'(1);
                end else begin
                    fin      = 1'b1;
                    f_status = ST_NOTFOUND;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state           = S_IDLE;
            n_done            = 1'b1;
            n_rsp.status      = f_status;
            n_rsp.read_value  = f_rd;
            n_rsp.found_index = f_fidx;
            n_rsp.list_length = 9'(n_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cmd <= n_cmd;
        r_pos <= n_pos;
        r_val <= n_val;
        r_rd  <= n_rd;
        r_rsp <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `ILE_ASSERT_IMP(a_cnt_cap, 1'b1, r_cnt <= CAP_CNT, "length above capacity")
    `ILE_ASSERT_IMP(a_done_idle, o_done, !busy, "result while busy")
    `ILE_ASSERT_NXT(a_acc_moves, start && !busy, busy || o_done, "item dropped")
    `ILE_ASSERT_NXT(a_scan_len, r_state == S_SCAN, $stable(r_cnt), "search changed length")
    `ILE_ASSERT_IMP(a_scan_idx, r_state == S_SCAN, CNT_W'(r_idx) < r_cnt, "search past end")

endmodule

// File: sv/ile_store.sv
`timescale 1ns / 1ps

module ile_store
    import ile_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [31:0]       i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [31:0]       o_rdata
);

    logic [31:0] r_mem [CAPACITY];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-first: a same-cycle write is seen on the next read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
